>>> hdl/mrtu_pkg.sv
// ----------------------------------------------------------------------------
// mrtu_pkg
// Shared types, constants and the crc helper for the modbus rtu register server
// ----------------------------------------------------------------------------
package mrtu_pkg;

  // input word operations
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_EOF  = 2'd1;
  localparam logic [1:0] OP_MEAS = 2'd2;

  // function codes
  localparam logic [7:0] FN_READ_HOLD  = 8'h03;
  localparam logic [7:0] FN_READ_INPUT = 8'h04;
  localparam logic [7:0] FN_WRITE_ONE  = 8'h06;

  // exception codes
  localparam logic [7:0] EXC_FUNCTION = 8'h01;
  localparam logic [7:0] EXC_ADDRESS  = 8'h02;
  localparam logic [7:0] EXC_VALUE    = 8'h03;

  localparam logic [7:0]  EXC_FLAG    = 8'h80;
  localparam logic [15:0] LOCK_KEY    = 16'h000A;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [8:0]  COUNT_MAX   = 9'd511;
  localparam logic [8:0]  FRAME_LEN   = 9'd8;
  localparam logic [8:0]  FRAME_MIN   = 9'd4;

  // register map
  localparam logic [15:0] REG_MEAS_LO = 16'd1;
  localparam logic [15:0] REG_MEAS_HI = 16'd11;
  localparam logic [15:0] REG_SET_LO  = 16'd14;
  localparam logic [15:0] REG_SET_HI  = 16'd29;
  localparam logic [15:0] REG_LOCK    = 16'd19;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  rx_byte;
    logic [3:0]  meas_index;
    logic [15:0] meas_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } out_word_t;

  // one byte through the reflected modbus crc
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/mrtu_ram.sv
// ----------------------------------------------------------------------------
// mrtu_ram
// Generic single port ram with registered read data
// ----------------------------------------------------------------------------
module mrtu_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/modbus_rtu_slave_register_server.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_server
// Modbus rtu slave: frame capture, crc check, register read/write, responses
// ----------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o | in_i (op, rx_byte, meas_*)
// out     | output    | out_valid_o / out_stall_i | out_o (tx_byte, tx_last)
// cfg     | input     | cfg_we_i                | cfg_wdata_i (station address)
//
// An end of frame is checked, then the response is sent byte by byte; each
// read register adds a register ram read (S_RREQ) before its two bytes.
// Input is stalled while a response is sent. Reset clears the register map
// through per entry valid bits.
// A stalled output holds the byte and pauses the response sequencer.
module modbus_rtu_slave_register_server #(
  parameter int MAX_READ_REGS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mrtu_pkg::in_word_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mrtu_pkg::out_word_t out_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);
  import mrtu_pkg::*;

  localparam int CntW = $clog2(MAX_READ_REGS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;
  localparam logic [2:0] S_RREQ = 3'd2;
  localparam logic [2:0] S_RHI  = 3'd3;
  localparam logic [2:0] S_RLO  = 3'd4;
  localparam logic [2:0] S_CRCL = 3'd5;
  localparam logic [2:0] S_CRCH = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [7:0]  station_q;
  logic [7:0]  head_q [8];
  logic [8:0]  count_q;
  logic [15:0] crc_q;
  logic [15:0] last2_q;
  logic        lock_q;
  logic [31:0] valid_q;
  logic        echo_q, is_read_q, rd_lock_q, rd_valid_q;
  logic [7:0]  b1_q, b2_q;
  logic [2:0]  idx_q;
  logic [4:0]  rd_addr_q;
  logic [CntW-1:0] left_q;
  logic [15:0] txcrc_q;
  logic        out_valid_q;
  out_word_t   out_q;

  logic        accept, can_emit, emit, emit_data;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        ram_we, ram_re;
  logic [4:0]  ram_addr;
  logic [15:0] ram_wdata, ram_rdata, rd_word;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign can_emit = !out_valid_q || !out_stall_i;

  // frame checks at end of frame
  logic [15:0] reg_a, val_v;
  logic [16:0] reg_end;
  logic        crc_ok, addr_ok, fn_known, len_ok, num_ok, run_ok;
  logic        wr_ok, wr_store;
  logic [15:0] wr_data;
  assign reg_a   = {head_q[2], head_q[3]};
  assign val_v   = {head_q[4], head_q[5]};
  assign reg_end = {1'b0, reg_a} + {1'b0, val_v} - 17'd1;
  assign crc_ok  = ({last2_q[7:0], last2_q[15:8]} == crc_q);
  assign addr_ok = (head_q[0] == station_q) || (head_q[0] == 8'h00);
  assign fn_known = (head_q[1] == FN_READ_HOLD) || (head_q[1] == FN_READ_INPUT) ||
                    (head_q[1] == FN_WRITE_ONE);
  assign len_ok  = (count_q == FRAME_LEN);
  assign num_ok  = (val_v != 16'd0) && (val_v <= 16'(MAX_READ_REGS));
  assign run_ok  = ((reg_a >= REG_MEAS_LO) && (reg_end <= {1'b0, REG_MEAS_HI})) ||
                   ((reg_a >= REG_SET_LO) && (reg_end <= {1'b0, REG_SET_HI}));

  // single register write value checks
  always_comb begin
    wr_ok    = 1'b0;
    wr_store = 1'b0;
    wr_data  = val_v;
    case (reg_a)
      16'd14: wr_ok = (val_v < 16'd2000);
      16'd15: begin
        wr_ok = 1'b1;
        if ((val_v < 16'd50) || (val_v > 16'd20000)) wr_data = 16'd0;
      end
      16'd16: wr_ok = (val_v <= 16'd5000);
      16'd17: wr_ok = (val_v >= 16'd150) && (val_v <= 16'd300);
      16'd18: wr_ok = (val_v <= 16'd1400);
      16'd19: wr_ok = 1'b1;
      16'd20, 16'd22, 16'd24, 16'd26, 16'd28:
        wr_ok = (val_v >= 16'd8000) && (val_v <= 16'd12000);
      16'd21, 16'd23, 16'd25, 16'd27, 16'd29:
        wr_ok = (val_v <= 16'd5000) || (val_v >= 16'd60536);
      default: wr_ok = 1'b0;
    endcase
    wr_store = wr_ok && (reg_a != REG_LOCK);
  end

  logic is_eof, is_write_ok;
  assign is_eof = accept && (in_i.op == OP_EOF);
  assign is_write_ok = (count_q >= FRAME_MIN) && crc_ok && addr_ok && fn_known &&
                       len_ok && (head_q[1] == FN_WRITE_ONE) && wr_ok;

  // register ram port
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = (state_q == S_RREQ);
    ram_addr  = rd_addr_q;
    ram_wdata = wr_data;
    if (accept && (in_i.op == OP_MEAS) && (in_i.meas_index >= 4'd1) &&
        (in_i.meas_index <= 4'd11)) begin
      ram_we    = 1'b1;
      ram_addr  = {1'b0, in_i.meas_index};
      ram_wdata = in_i.meas_value;
    end else if (is_eof && is_write_ok && wr_store) begin
      ram_we   = 1'b1;
      ram_addr = reg_a[4:0];
    end
  end

  mrtu_ram #(.Width(16), .Depth(32)) u_regs (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign rd_word = rd_lock_q ? (lock_q ? LOCK_KEY : 16'h0000) :
                   (rd_valid_q ? ram_rdata : 16'h0000);

  // response byte selection
  always_comb begin
    emit_byte = 8'h00;
    emit_last = 1'b0;
    emit_data = 1'b0;
    case (state_q)
      S_HDR: begin
        emit_data = 1'b1;
        case (idx_q)
          3'd0: emit_byte = head_q[0];
          3'd1: emit_byte = echo_q ? head_q[1] : b1_q;
          3'd2: emit_byte = echo_q ? head_q[2] : b2_q;
          default: emit_byte = head_q[idx_q];
        endcase
        emit_last = echo_q && (idx_q == 3'd7);
      end
      S_RHI: begin emit_byte = rd_word[15:8]; emit_data = 1'b1; end
      S_RLO: begin emit_byte = rd_word[7:0];  emit_data = 1'b1; end
      S_CRCL: emit_byte = txcrc_q[7:0];
      S_CRCH: begin emit_byte = txcrc_q[15:8]; emit_last = 1'b1; end
      default: emit_byte = 8'h00;
    endcase
  end

  assign emit = can_emit && ((state_q == S_HDR) || (state_q == S_RHI) ||
                (state_q == S_RLO) || (state_q == S_CRCL) || (state_q == S_CRCH));

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (is_eof && (count_q >= FRAME_MIN) && crc_ok && addr_ok &&
            (head_q[1] != 8'h00)) state_d = S_HDR;
      end
      S_HDR: begin
        if (emit) begin
          if (echo_q) begin
            if (idx_q == 3'd7) state_d = S_IDLE;
          end else if (idx_q == 3'd2) begin
            state_d = is_read_q ? S_RREQ : S_CRCL;
          end
        end
      end
      S_RREQ: state_d = S_RHI;
      S_RHI:  if (emit) state_d = S_RLO;
      S_RLO:  if (emit) state_d = (left_q == CntW'(1)) ? S_CRCL : S_RREQ;
      S_CRCL: if (emit) state_d = S_CRCH;
      S_CRCH: if (emit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      station_q   <= 8'd1;
      count_q     <= '0;
      crc_q       <= CRC_INIT;
      last2_q     <= '0;
      lock_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) station_q <= cfg_wdata_i;
      if (accept && (in_i.op == OP_BYTE)) begin
        if (count_q >= 9'd2) crc_q <= crc_feed(crc_q, last2_q[15:8]);
        last2_q <= {last2_q[7:0], in_i.rx_byte};
        if (count_q != COUNT_MAX) count_q <= count_q + 9'd1;
      end else if (is_eof) begin
        count_q <= '0;
        crc_q   <= CRC_INIT;
        last2_q <= '0;
        if (is_write_ok && (reg_a == REG_LOCK)) lock_q <= (val_v == LOCK_KEY);
      end
      if (ram_we) valid_q[ram_addr] <= 1'b1;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept && (in_i.op == OP_BYTE) && (count_q < FRAME_LEN)) begin
      head_q[count_q[2:0]] <= in_i.rx_byte;
    end
    if (state_q == S_IDLE) begin
      idx_q     <= '0;
      txcrc_q   <= CRC_INIT;
      rd_addr_q <= reg_a[4:0];
      left_q    <= val_v[CntW-1:0];
      b1_q      <= head_q[1];
      b2_q      <= {val_v[6:0], 1'b0};
      echo_q    <= 1'b0;
      is_read_q <= 1'b0;
      if (!fn_known) begin
        b1_q <= head_q[1] | EXC_FLAG;
        b2_q <= EXC_FUNCTION;
      end else if (!len_ok) begin
        b1_q <= head_q[1] | EXC_FLAG;
        b2_q <= EXC_VALUE;
      end else if (head_q[1] == FN_WRITE_ONE) begin
        if (wr_ok) begin
          echo_q <= 1'b1;
        end else begin
          b1_q <= head_q[1] | EXC_FLAG;
          b2_q <= EXC_ADDRESS;
        end
      end else if (!num_ok) begin
        b1_q <= head_q[1] | EXC_FLAG;
        b2_q <= EXC_VALUE;
      end else if (!run_ok) begin
        b1_q <= head_q[1] | EXC_FLAG;
        b2_q <= EXC_ADDRESS;
      end else begin
        is_read_q <= 1'b1;
      end
    end
    if (state_q == S_RREQ) begin
      rd_lock_q  <= ({11'd0, rd_addr_q} == REG_LOCK);
      rd_valid_q <= valid_q[rd_addr_q];
    end
    if (emit) begin
      if (state_q == S_HDR) idx_q <= idx_q + 3'd1;
      if (emit_data) txcrc_q <= crc_feed(txcrc_q, emit_byte);
      if (state_q == S_RLO) begin
        rd_addr_q <= rd_addr_q + 5'd1;
        left_q    <= left_q - CntW'(1);
      end
      out_q.tx_byte <= emit_byte;
      out_q.tx_last <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives frames, ends of frame and measurement updates into the modbus rtu
// register server and compares every response word with a local prediction
// ----------------------------------------------------------------------------
module tb_top;
  import mrtu_pkg::*;

  localparam int WATCHDOG = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_o;
  logic      cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd1;

  modbus_rtu_slave_register_server dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_o(out_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  own_addr;
  logic [7:0]  head_q [8];
  logic [8:0]  rx_count;
  logic [15:0] rx_crc;
  logic [15:0] tail_q;
  logic [15:0] meas_q [11];
  logic [15:0] set_q [16];
  logic        lock_q;

  out_word_t   tx_expect_q [$];
  int          mismatches = 0;
  int          idle_cnt = 0;
  bit          no_idle = 1'b0;
  bit          hold_rx = 1'b0;

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    c ^= {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic bit reg_read(logic [15:0] a, output logic [15:0] v);
    v = '0;
    if (a >= REG_MEAS_LO && a <= REG_MEAS_HI) begin
      v = meas_q[a - 1];
      return 1'b1;
    end
    if (a == REG_LOCK) begin
      v = lock_q ? LOCK_KEY : 16'h0;
      return 1'b1;
    end
    if (a >= REG_SET_LO && a <= REG_SET_HI) begin
      v = set_q[a - 14];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit reg_write(logic [15:0] a, logic [15:0] v);
    bit ok;
    ok = 1'b0;
    case (a)
      16'd14: ok = v < 2000;
      16'd15: begin
        if (v < 50 || v > 20000) v = 0;
        ok = 1'b1;
      end
      16'd16: ok = v <= 5000;
      16'd17: ok = v >= 150 && v <= 300;
      16'd18: ok = v <= 1400;
      16'd19: begin
        lock_q = (v == LOCK_KEY);
        return 1'b1;
      end
      16'd20, 16'd22, 16'd24, 16'd26, 16'd28: ok = v >= 8000 && v <= 12000;
      16'd21, 16'd23, 16'd25, 16'd27, 16'd29: ok = v <= 5000 || v >= 16'd60536;
      default: return 1'b0;
    endcase
    if (ok) set_q[a - 14] = v;
    return ok;
  endfunction

  // append bytes with crc and last flag
  function automatic void queue_reply(logic [7:0] b [$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (b[i]) c = crc_byte(c, b[i]);
    b.push_back(c[7:0]);
    b.push_back(c[15:8]);
    foreach (b[i]) tx_expect_q.push_back('{tx_byte: b[i], tx_last: i == b.size() - 1});
  endfunction

  function automatic void queue_exception(logic [7:0] code);
    logic [7:0] b [$];
    b = '{head_q[0], head_q[1] | EXC_FLAG, code};
    queue_reply(b);
  endfunction

  function automatic void answer_frame();
    logic [15:0] got, ra, nv, d;
    logic [7:0]  fn;
    logic [7:0]  b [$];
    if (rx_count < FRAME_MIN) return;
    got = {tail_q[7:0], tail_q[15:8]};
    if (got != rx_crc) return;
    if (head_q[0] != own_addr && head_q[0] != 8'h00) return;
    fn = head_q[1];
    if (fn == 8'h00) return;
    if (fn != FN_READ_HOLD && fn != FN_READ_INPUT && fn != FN_WRITE_ONE) begin
      queue_exception(EXC_FUNCTION);
      return;
    end
    if (rx_count != FRAME_LEN) begin
      queue_exception(EXC_VALUE);
      return;
    end
    ra = {head_q[2], head_q[3]};
    nv = {head_q[4], head_q[5]};
    if (fn == FN_WRITE_ONE) begin
      if (!reg_write(ra, nv)) begin
        queue_exception(EXC_ADDRESS);
        return;
      end
      for (int i = 0; i < 8; i++)
        tx_expect_q.push_back('{tx_byte: head_q[i], tx_last: i == 7});
      return;
    end
    if (nv == 0 || nv > 32) begin
      queue_exception(EXC_VALUE);
      return;
    end
    for (int i = 0; i < nv; i++)
      if (!reg_read(ra + i[15:0], d)) begin
        queue_exception(EXC_ADDRESS);
        return;
      end
    b = '{head_q[0], fn, nv[6:0] << 1};
    for (int i = 0; i < nv; i++) begin
      void'(reg_read(ra + i[15:0], d));
      b.push_back(d[15:8]);
      b.push_back(d[7:0]);
    end
    queue_reply(b);
  endfunction

  function automatic void predict(in_word_t w);
    case (w.op)
      OP_BYTE: begin
        if (rx_count >= 2) rx_crc = crc_byte(rx_crc, tail_q[15:8]);
        tail_q = {tail_q[7:0], w.rx_byte};
        if (rx_count < 8) head_q[rx_count[2:0]] = w.rx_byte;
        if (rx_count < COUNT_MAX) rx_count++;
      end
      OP_EOF: begin
        answer_frame();
        rx_count = '0;
        rx_crc = CRC_INIT;
        tail_q = '0;
      end
      OP_MEAS: if (w.meas_index >= 1 && w.meas_index <= 11)
        meas_q[w.meas_index - 1] = w.meas_value;
      default: ;
    endcase
  endfunction

  // receive side: stall at random, hold off on request, or never stall in no_idle mode
  always @(posedge clk_i) begin
    if (hold_rx) out_stall_i <= 1'b1;
    else if (no_idle) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < 17);
  end

  // response checker
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tx_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: byte %02h last %0b", out_o.tx_byte, out_o.tx_last);
      end else begin
        exp_w = tx_expect_q.pop_front();
        if (out_o.tx_byte !== exp_w.tx_byte || out_o.tx_last !== exp_w.tx_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     exp_w.tx_byte, exp_w.tx_last, out_o.tx_byte, out_o.tx_last);
        end
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cnt <= 0;
    else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt > WATCHDOG) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // one word through the handshake, with predicted response
  task automatic send_word(in_word_t w);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict(w);
  endtask

  task automatic send_byte(logic [7:0] b);
    in_word_t w;
    w = '0;
    w.op = OP_BYTE;
    w.rx_byte = b;
    w.meas_index = 4'($urandom);
    w.meas_value = 16'($urandom);
    send_word(w);
  endtask

  task automatic send_eof();
    in_word_t w;
    w = in_word_t'($urandom);
    w.op = OP_EOF;
    send_word(w);
  endtask

  task automatic send_meas(logic [3:0] idx, logic [15:0] v);
    in_word_t w;
    w = '0;
    w.op = OP_MEAS;
    w.rx_byte = 8'($urandom);
    w.meas_index = idx;
    w.meas_value = v;
    send_word(w);
  endtask

  // frame of body bytes plus crc, optionally corrupted
  task automatic send_frame(logic [7:0] body [$], bit bad_crc);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body[i]) begin
      c = crc_byte(c, body[i]);
      send_byte(body[i]);
    end
    if (bad_crc) c ^= 16'(1 << $urandom_range(15));
    send_byte(c[7:0]);
    send_byte(c[15:8]);
    send_eof();
  endtask

  // stop offering and wait for every predicted word
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tx_expect_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_address(logic [7:0] a);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    own_addr = a;
  endtask

  function automatic logic [7:0] pick_addr();
    int r;
    r = $urandom_range(99);
    if (r < 70) return own_addr;
    if (r < 85) return 8'h00;
    return 8'($urandom);
  endfunction

  // directed rows: body bytes, crc corruption, expected response (empty = predictor)
  typedef struct {
    logic [7:0] body [$];
    bit         bad;
    logic [7:0] reply [$];
  } row_t;

  task automatic run_table();
    row_t rows [$];
    row_t r;
    int   pos;
    r.bad = 0; r.reply = {};
    r.body = '{8'h01, FN_READ_HOLD, 8'h00, 8'h01, 8'h00, 8'h02}; rows.push_back(r);
    r.body = '{8'h01, FN_READ_INPUT, 8'h00, 8'h0E, 8'h00, 8'h10}; rows.push_back(r);
    r.body = '{8'h00, FN_WRITE_ONE, 8'h00, 8'h13, 8'h00, 8'h0A}; rows.push_back(r);
    r.body = '{8'h01, FN_WRITE_ONE, 8'h00, 8'h0F, 8'h00, 8'h05}; rows.push_back(r);
    r.body = '{8'h01, FN_WRITE_ONE, 8'h00, 8'h15, 8'hEC, 8'h78}; rows.push_back(r);
    r.body = '{8'h01, FN_WRITE_ONE, 8'h00, 8'h14, 8'h2E, 8'hE0}; rows.push_back(r);
    r.body = '{8'h01, FN_READ_HOLD, 8'h00, 8'h01, 8'h00, 8'h20}; rows.push_back(r);
    r.body = '{8'h01, FN_READ_HOLD, 8'h00, 8'h14, 8'h00, 8'h0A}; rows.push_back(r);
    // known exception replies
    r.body = '{8'h01, 8'h07, 8'hFF};
    r.reply = '{8'h01, 8'h87, EXC_FUNCTION}; rows.push_back(r);
    r.body = '{8'h01, FN_READ_HOLD, 8'h00, 8'h01, 8'h00, 8'h21};
    r.reply = '{8'h01, 8'h83, EXC_VALUE}; rows.push_back(r);
    r.body = '{8'h01, FN_READ_HOLD, 8'h00, 8'h01, 8'h00, 8'h00};
    r.reply = '{8'h01, 8'h83, EXC_VALUE}; rows.push_back(r);
    r.body = '{8'h01, FN_READ_INPUT, 8'h00, 8'h00, 8'h00, 8'h01};
    r.reply = '{8'h01, 8'h84, EXC_ADDRESS}; rows.push_back(r);
    r.body = '{8'h01, FN_READ_HOLD, 8'hFF, 8'hFF, 8'h00, 8'h01};
    r.reply = '{8'h01, 8'h83, EXC_ADDRESS}; rows.push_back(r);
    r.body = '{8'h01, FN_WRITE_ONE, 8'h00, 8'h11, 8'hFF, 8'hFF};
    r.reply = '{8'h01, 8'h86, EXC_ADDRESS}; rows.push_back(r);
    r.body = '{8'h01, FN_WRITE_ONE, 8'h00, 8'h0C, 8'h00, 8'h00};
    r.reply = '{8'h01, 8'h86, EXC_ADDRESS}; rows.push_back(r);
    r.body = '{8'h01, FN_READ_HOLD, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00};
    r.reply = '{8'h01, 8'h83, EXC_VALUE}; rows.push_back(r);
    // dropped frames: no reply
    r.reply = {};
    r.body = '{8'h01, FN_READ_HOLD, 8'h00, 8'h01, 8'h00, 8'h01}; r.bad = 1; rows.push_back(r);
    r.bad = 0;
    r.body = '{8'h02, FN_READ_HOLD, 8'h00, 8'h01, 8'h00, 8'h01}; rows.push_back(r);
    r.body = '{8'h01, 8'h00, 8'h00, 8'h01}; rows.push_back(r);
    r.body = '{8'h01}; rows.push_back(r);

    foreach (rows[i]) begin
      // start each row with nothing outstanding so the queue index is stable
      drain();
      pos = tx_expect_q.size();
      send_frame(rows[i].body, rows[i].bad);
      if (rows[i].reply.size() != 0 || rows[i].body.size() < 2 || rows[i].bad) begin
        // the table value must agree with the prediction
        logic [15:0] c;
        logic [7:0]  b [$];
        int          n;
        b = rows[i].reply;
        n = b.size();
        if (n != 0) begin
          c = CRC_INIT;
          foreach (b[k]) c = crc_byte(c, b[k]);
          b.push_back(c[7:0]);
          b.push_back(c[15:8]);
        end
        if (tx_expect_q.size() - pos != b.size()) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: expected %0d reply bytes, predicted %0d",
                     i, b.size(), tx_expect_q.size() - pos);
        end else
          foreach (b[k])
            if (tx_expect_q[pos + k].tx_byte != b[k]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("table row %0d: byte %0d expected %02h, predicted %02h",
                         i, k, b[k], tx_expect_q[pos + k].tx_byte);
            end
      end
    end
    // short frame with nothing before it, an ignored op and out of range measurement indices
    send_eof();
    send_word('{op: 2'd3, rx_byte: 8'hFF, meas_index: 4'hF, meas_value: 16'hFFFF});
    send_meas(4'd0, 16'hFFFF);
    send_meas(4'd12, 16'h1234);
  endtask

  task automatic random_frame();
    logic [7:0]  b [$];
    logic [15:0] ra, nv;
    int          k;
    k = $urandom_range(99);
    if (k < 40) begin
      ra = ($urandom_range(1) ? 16'($urandom_range(0, 13)) : 16'($urandom_range(12, 31)));
      nv = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 18));
      b = '{pick_addr(), $urandom_range(1) ? FN_READ_HOLD : FN_READ_INPUT,
            ra[15:8], ra[7:0], nv[15:8], nv[7:0]};
    end else if (k < 80) begin
      ra = 16'($urandom_range(12, 31));
      case ($urandom_range(3))
        0: nv = 16'($urandom);
        1: nv = 16'($urandom_range(0, 2100));
        2: nv = 16'($urandom_range(7900, 20100));
        default: nv = 16'($urandom_range(60000, 65535));
      endcase
      if ($urandom_range(19) == 0) ra = 16'($urandom);
      b = '{pick_addr(), FN_WRITE_ONE, ra[15:8], ra[7:0], nv[15:8], nv[7:0]};
    end else begin
      b = {};
      repeat ($urandom_range(0, 10)) b.push_back(8'($urandom));
      if (b.size() > 0 && $urandom_range(1)) b[0] = pick_addr();
    end
    send_frame(b, $urandom_range(19) == 0);
  endtask

  task automatic random_run(int n_frames);
    for (int i = 0; i < n_frames; i++) begin
      if ($urandom_range(4) == 0) send_meas(4'($urandom), 16'($urandom));
      else random_frame();
    end
  endtask

  initial begin
    own_addr = 8'd1;
    rx_count = '0;
    rx_crc = CRC_INIT;
    tail_q = '0;
    lock_q = 1'b0;
    foreach (head_q[i]) head_q[i] = '0;
    foreach (meas_q[i]) meas_q[i] = '0;
    foreach (set_q[i]) set_q[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_meas(4'd1, 16'hFFFF);
    send_meas(4'd11, 16'h8001);
    run_table();

    // receiver holds off while the sender keeps going
    hold_rx = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      random_run(6);
    join

    set_address(8'd247);
    random_run(6);
    // sender pauses for all replies
    drain();

    no_idle = 1'b1;
    random_run(8);
    no_idle = 1'b0;

    set_address(8'($urandom_range(2, 246)));
    random_run(5);
    set_address(8'd1);
    random_run(3);

    drain();
    if (mismatches == 0 && tx_expect_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
